// ----- rtl/core/mexp_pkg.sv -----
// Package: shared constants for the modular exponentiation core.
package mexp_pkg;
    localparam int EXP_BITS_DEF = 64;
    localparam int MOD_BITS_DEF = 32;
    localparam logic [31:0] MODULUS_RESET = 32'd1000000007;
    localparam int BASE_W = 32;
    localparam int EXPONENT_W = 63;
    localparam int RESULT_W = 32;
endpackage

// ----- rtl/core/mexp_mulmod.sv -----
// Bit-serial modular multiplier: a * b mod m, one bit of b per cycle.
module mexp_mulmod
    import mexp_pkg::*;
#(
    parameter int MOD_BITS = MOD_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                go,
    input  logic [MOD_BITS-1:0] a,
    input  logic [MOD_BITS-1:0] b,
    input  logic [MOD_BITS-1:0] m,
    output logic                done,
    output logic [MOD_BITS-1:0] product
);
    localparam int CW = $clog2(MOD_BITS + 1);

    logic                run_reg, run_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [MOD_BITS-1:0] a_reg, a_next;
    logic [MOD_BITS-1:0] b_reg, b_next;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic                done_reg, done_next;
    logic [MOD_BITS:0]   dbl;
    logic [MOD_BITS:0]   d1;
    logic [MOD_BITS:0]   sum;
    logic [MOD_BITS-1:0] d1r;

    always_comb
    begin
        // Horner step, MSB first: acc = 2*acc (+a), each reduced once.
        dbl = {acc_reg, 1'b0};
        d1  = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
        d1r = d1[MOD_BITS-1:0];
        sum = {1'b0, d1r};
        if (b_reg[MOD_BITS-1])
        begin
            sum = {1'b0, d1r} + {1'b0, a_reg};
            sum = (sum >= {1'b0, m}) ? sum - {1'b0, m} : sum;
        end
        run_next  = run_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        if (go)
        begin
            run_next = 1'b1;
            cnt_next = CW'(MOD_BITS);
            a_next   = a;
            b_next   = b;
            acc_next = '0;
        end
        else if (run_reg)
        begin
            acc_next = sum[MOD_BITS-1:0];
            b_next   = {b_reg[MOD_BITS-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

// ----- rtl/core/modular_exponentiation_core.sv -----
// Top level: square-and-multiply modular exponentiation with a bit-serial multiplier.
//
// A word is taken when start is high and busy is low. The base is first reduced
// by the modulus one bit per cycle, then the exponent is walked LSB first: each
// bit passes through the dispatch state, a multiply when the bit is set and a
// squaring, except that the walk stops right after the multiply of the highest
// set bit. Every multiply or squaring goes through the one shared bit-serial
// multiplier. busy drops in the strobe cycle, so the next word can be taken at
// the edge that ends it. A modulus of zero gives 0 with the strobe in the cycle
// right after acceptance and busy never rising. power_result is valid for one
// cycle while done is high; the receiver cannot stall it. Write the modulus
// through cfg_valid/cfg_ready only while idle.
module modular_exponentiation_core
    import mexp_pkg::*;
#(
    parameter int EXP_BITS = EXP_BITS_DEF,
    parameter int MOD_BITS = MOD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [BASE_W-1:0]     base_value,
    input  logic [EXPONENT_W-1:0] exponent,
    output logic                  done,
    output logic [RESULT_W-1:0]   power_result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [31:0]           cfg_data
);
    localparam int EW = (EXP_BITS < EXPONENT_W) ? EXP_BITS : EXPONENT_W;
    localparam int CW = $clog2(BASE_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SQR  = 3'd3;
    localparam logic [2:0] S_WAIT = 3'd4;
    localparam logic [2:0] S_BIT  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [2:0]          after_reg, after_next;
    logic [MOD_BITS-1:0] mod_reg;
    logic [MOD_BITS-1:0] acc_reg, acc_next;
    logic [MOD_BITS-1:0] sq_reg, sq_next;
    logic [EW-1:0]       e_reg, e_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [BASE_W-1:0]   base_hold_reg, base_hold_next;
    logic                done_reg, done_next;
    logic                go;
    logic [MOD_BITS-1:0] op_a, op_b;
    logic                mm_done;
    logic [MOD_BITS-1:0] mm_p;
    logic [MOD_BITS:0]   red_t;

    mexp_mulmod #(.MOD_BITS(MOD_BITS)) u_mulmod
    (
        .clk(clk), .rst_n(rst_n), .go(go), .a(op_a), .b(op_b), .m(mod_reg),
        .done(mm_done), .product(mm_p)
    );

    assign cfg_ready = 1'b1;

    always_comb
    begin
        // Base reduction step: shift in the next base bit, MSB first, and
        // subtract the modulus once; 2*r + 1 stays below 2*m.
        red_t = {sq_reg, base_hold_reg[BASE_W-1]};
        if (red_t >= {1'b0, mod_reg})
            red_t = red_t - {1'b0, mod_reg};

        state_next     = state_reg;
        after_next     = after_reg;
        acc_next       = acc_reg;
        sq_next        = sq_reg;
        e_next         = e_reg;
        cnt_next       = cnt_reg;
        base_hold_next = base_hold_reg;
        done_next      = 1'b0;
        go             = 1'b0;
        op_a           = sq_reg;
        op_b           = sq_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (mod_reg == '0)
                    begin
                        // Zero modulus: answer 0 at once.
                        acc_next  = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        e_next         = exponent[EW-1:0];
                        base_hold_next = base_value;
                        sq_next        = '0;
                        cnt_next       = '0;
                        state_next     = S_RED;
                    end
                end
            end
            S_RED:
            begin
                sq_next        = red_t[MOD_BITS-1:0];
                base_hold_next = {base_hold_reg[BASE_W-2:0], 1'b0};
                cnt_next       = cnt_reg + 1'b1;
                if (cnt_reg == CW'(BASE_W - 1))
                begin
                    // Start the running product at 1 mod m.
                    acc_next   = (mod_reg == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
                    state_next = S_BIT;
                end
            end
            S_BIT:
            begin
                // Stop once no set exponent bits remain.
                if (e_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (e_reg[0])
                    state_next = S_MUL;
                else
                    state_next = S_SQR;
            end
            S_MUL:
            begin
                op_a       = acc_reg;
                op_b       = sq_reg;
                go         = 1'b1;
                state_next = S_WAIT;
                after_next = S_MUL;
            end
            S_SQR:
            begin
                go         = 1'b1;
                state_next = S_WAIT;
                after_next = S_SQR;
            end
            S_WAIT:
            begin
                if (mm_done)
                begin
                    if (after_reg == S_MUL)
                    begin
                        acc_next = mm_p;
                        // Drop the last squaring after the highest set bit.
                        if ((e_reg >> 1) == '0)
                        begin
                            done_next  = 1'b1;
                            state_next = S_IDLE;
                        end
                        else
                            state_next = S_SQR;
                    end
                    else
                    begin
                        sq_next    = mm_p;
                        e_next     = e_reg >> 1;
                        state_next = S_BIT;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            after_reg <= S_IDLE;
            done_reg  <= 1'b0;
            mod_reg   <= MODULUS_RESET[MOD_BITS-1:0];
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            if (cfg_valid && cfg_ready)
                mod_reg <= cfg_data[MOD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        sq_reg        <= sq_next;
        e_reg         <= e_next;
        base_hold_reg <= base_hold_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign power_result = RESULT_W'(acc_reg);
endmodule

// ----- tb/tb_modular_exponentiation_core.sv -----
// Testbench for the modular exponentiation core: directed and random items checked by a scoreboard.
module tb_modular_exponentiation_core
    import mexp_pkg::*;
();

    // Hold the expected powers in arrival order and compare each result strobe.
    class power_scoreboard;
        logic [RESULT_W-1:0] expected_powers[$];
        int                  errors = 0;

        function void note_item(logic [RESULT_W-1:0] value);
            expected_powers = {expected_powers, value};
        endfunction

        function void check_power(logic [RESULT_W-1:0] actual);
            logic [RESULT_W-1:0] want;
            if (expected_powers.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %0d", $time, actual);
                errors++;
            end
            else
            begin
                want = expected_powers.pop_front();
                if (want !== actual)
                begin
                    $display("%0t: power_result mismatch, expected %0d, actual %0d",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [BASE_W-1:0]     base_value = '0;
    logic [EXPONENT_W-1:0] exponent = '0;
    logic                  done;
    logic [RESULT_W-1:0]   power_result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [31:0]           cfg_data = '0;

    power_scoreboard       board;
    logic [31:0]           modulus_shadow;
    int                    burst_left;

    modular_exponentiation_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .base_value(base_value), .exponent(exponent), .done(done),
        .power_result(power_result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    // Square-and-multiply over all 63 exponent bits, base reduced up front.
    function automatic logic [RESULT_W-1:0] predict_power(logic [31:0] m,
                                                          logic [BASE_W-1:0] b,
                                                          logic [EXPONENT_W-1:0] e);
        logic [63:0] acc;
        logic [63:0] sq;
        logic [63:0] m64;
        if (m == 0)
            return '0;
        m64 = {32'd0, m};
        acc = 64'd1 % m64;
        sq  = {32'd0, b} % m64;
        for (int i = 0; i < EXPONENT_W; i++)
        begin
            if (e[i])
                acc = (acc * sq) % m64;
            sq = (sq * sq) % m64;
        end
        return acc[RESULT_W-1:0];
    endfunction

    // Check every result strobe at the edge that ends its cycle.
    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_power(power_result);
    end

    // Drive one word; random gaps between bursts move start across all phases.
    task automatic send_item(logic [BASE_W-1:0] b, logic [EXPONENT_W-1:0] e);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 6);
            repeat ($urandom_range(0, 40)) @(posedge clk);
        end
        burst_left--;
        start      <= 1'b1;
        base_value <= b;
        exponent   <= e;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_item(predict_power(modulus_shadow, b, e));
        start <= 1'b0;
        @(posedge clk);
    endtask

    // Drain, then write the modulus while idle.
    task automatic write_modulus(logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        modulus_shadow = value;
        @(posedge clk);
    endtask

    task automatic drain();
        @(posedge clk);
        while (board.expected_powers.size() != 0 || busy)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [EXPONENT_W-1:0] random_exponent();
        logic [EXPONENT_W-1:0] e;
        e = EXPONENT_W'({$urandom, $urandom});
        case ($urandom_range(0, 3))
            0: e = e & 63'hF;
            1: e = e & 63'hFFFF_FFFF;
            default: ;
        endcase
        return e;
    endfunction

    initial
    begin
        logic [31:0] moduli[5];
        board = new();
        modulus_shadow = MODULUS_RESET;
        burst_left = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset modulus and moduli 1, 0xFFFFFFFF, 0 and 2, zero and extreme exponents, unreduced base.
        send_item(32'd0, 63'd0);
        send_item(32'hFFFF_FFFF, 63'd0);
        send_item(32'hFFFF_FFFF, 63'd1);
        send_item(32'd1000000008, 63'd1);
        send_item(32'd2, 63'd10);
        send_item(32'hFFFF_FFFF, {EXPONENT_W{1'b1}});
        send_item(32'd0, 63'd5);
        send_item(32'h5555_5555, 63'h2AAA_AAAA_AAAA_AAAA);
        write_modulus(32'd1);
        send_item(32'd7, 63'd0);
        send_item(32'hFFFF_FFFF, {EXPONENT_W{1'b1}});
        write_modulus(32'hFFFF_FFFF);
        send_item(32'hFFFF_FFFF, 63'd1);
        send_item(32'hFFFF_FFFE, {EXPONENT_W{1'b1}});
        send_item(32'd3, 63'h5555_5555_5555_5555);
        write_modulus(32'd0);
        send_item(32'd9, 63'd3);
        write_modulus(32'd2);
        send_item(32'd3, 63'd7);

        // Random phases over several moduli, extremes among them.
        moduli = '{32'd97, 32'h8000_0000, 32'hFFFF_FFFB, 32'd1000000007, 32'd0};
        for (int p = 0; p < 5; p++)
        begin
            write_modulus(p == 4 ? $urandom_range(2, 32'hFFFF_FFFF) : moduli[p]);
            for (int n = 0; n < 25; n++)
                send_item($urandom, random_exponent());
        end

        drain();
        if (board.errors == 0)
            $display("modular_exponentiation_core test passed");
        else
            $display("modular_exponentiation_core test failed");
        $finish;
    end

    initial
    begin
        #30000000;
        $display("modular_exponentiation_core test failed");
        $finish;
    end
endmodule

// ----- modular_exponentiation_core.f -----
rtl/core/mexp_pkg.sv
rtl/core/mexp_mulmod.sv
rtl/core/modular_exponentiation_core.sv
tb/tb_modular_exponentiation_core.sv
